// ----- rtl/core/pgalloc_pkg.sv -----
// pgalloc_pkg: operation and status codes, register indexes and the
// command/status structs shared by the page allocator controller and datapath.
// No dependencies.
`default_nettype none

package pgalloc_pkg;

   localparam int PAGE_SHIFT = 12;

   // request opcodes
   localparam logic [2:0] OP_ALLOC   = 3'd0;
   localparam logic [2:0] OP_RELEASE = 3'd1;
   localparam logic [2:0] OP_ADDREF  = 3'd2;
   localparam logic [2:0] OP_READ    = 3'd3;
   localparam logic [2:0] OP_INIT    = 3'd4;

   // response status codes
   localparam logic [2:0] STAT_OK      = 3'd0;
   localparam logic [2:0] STAT_EMPTY   = 3'd1;
   localparam logic [2:0] STAT_BADADDR = 3'd2;
   localparam logic [2:0] STAT_UNDER   = 3'd3;
   localparam logic [2:0] STAT_OVER    = 3'd4;
   localparam logic [2:0] STAT_NONZERO = 3'd5;

   // register indexes
   localparam logic CSR_POOL_START = 1'b0;
   localparam logic CSR_PAGE_COUNT = 1'b1;

   localparam logic [31:0] POOL_START_RESET = 32'h8000_0000;
   localparam logic [12:0] PAGE_COUNT_RESET = 13'd4096;

   typedef struct packed {
      logic accept;      // take the request, start memory reads
      logic pop;         // read the count of the page just popped
      logic sweep;       // clear one count entry per cycle
      logic sweep_init;  // during the sweep also rebuild the free stack
      logic commit;      // update memories and load the response
   } cmd_type;

   typedef struct packed {
      logic empty;       // free stack holds no page
      logic sweep_last;  // sweep is on its final entry
      logic out_free;    // response register can take a new result
   } stat_type;

endpackage

`default_nettype wire

// ----- rtl/core/pgalloc_ctrl.sv -----
// pgalloc_ctrl: sequencer of the page allocator.
// Depends on pgalloc_pkg for the opcodes and the command/status structs.
`default_nettype none

module pgalloc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [2:0]           req_opcode,
   output logic                 req_stall,
   input  pgalloc_pkg::stat_type stat,
   output pgalloc_pkg::cmd_type  cmd
);
   import pgalloc_pkg::*;

   typedef enum logic [2:0] {
      ST_RST_CLEAR,
      ST_IDLE,
      ST_POP,
      ST_INIT_CLEAR,
      ST_MODIFY
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_RST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_opcode)
                  OP_ALLOC: state_in = stat.empty ? ST_MODIFY : ST_POP;
                  OP_INIT:  state_in = ST_INIT_CLEAR;
                  default:  state_in = ST_MODIFY;
               endcase
            end
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_MODIFY;
         end
         ST_INIT_CLEAR: begin
            cmd.sweep      = 1'b1;
            cmd.sweep_init = 1'b1;
            if (stat.sweep_last) state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            // hold the result until the response register is free
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/pgalloc_dpath.sv -----
// pgalloc_dpath: configuration registers, count memory, free stack memory,
// address checks and the response register of the page allocator.
// Depends on pgalloc_pkg for codes and the command/status structs.
`default_nettype none

module pgalloc_dpath #(
   parameter int MAX_PAGES  = 4096,
   parameter int COUNT_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic                 csr_index,
   input  logic [31:0]          csr_wdata,
   input  logic [2:0]           req_opcode,
   input  logic [31:0]          req_address,
   input  pgalloc_pkg::cmd_type  cmd,
   output pgalloc_pkg::stat_type stat,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_status,
   output logic [31:0]          rsp_page_address,
   output logic [15:0]          rsp_ref_count,
   output logic                 rsp_page_freed
);
   import pgalloc_pkg::*;

   localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int DEP_W = $clog2(MAX_PAGES + 1);
   localparam int PG_W  = 32 - PAGE_SHIFT;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   // configuration
   logic [31:0]      pool_start_ff;
   logic [12:0]      page_count_ff;
   logic [DEP_W-1:0] pool_pages;
   logic [PG_W:0]    room;
   logic [PG_W:0]    pool_next;

   // memories
   logic [COUNT_BITS-1:0] count_mem [MAX_PAGES];
   logic [IDX_W-1:0]      stack_mem [MAX_PAGES];
   logic [COUNT_BITS-1:0] count_rd_ff;
   logic [IDX_W-1:0]      stack_rd_ff;

   // request context
   logic [2:0]       op_ff;
   logic             unaligned_ff;
   logic             bad_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [DEP_W-1:0] depth_ff, depth_in;
   logic [IDX_W-1:0] sweep_ff;

   // response register
   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [31:0] rsp_page_address_ff;
   logic [15:0] rsp_ref_count_ff;
   logic        rsp_page_freed_ff;

   // decode of the incoming request
   logic [PG_W-1:0]  addr_pg, base_pg, diff;
   logic             in_range, unaligned;
   logic [IDX_W-1:0] req_idx;
   logic [DEP_W-1:0] depth_dec;
   logic             cnt_re, stk_re;
   logic [IDX_W-1:0] cnt_raddr;

   // modify step
   logic [2:0]            st_c;
   logic [31:0]           paddr_c;
   logic [COUNT_BITS-1:0] cnt_c, cnt_wdata;
   logic                  cnt_we, push, freed_c;
   logic                  sweep_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_start_ff <= POOL_START_RESET;
         page_count_ff <= PAGE_COUNT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_POOL_START: pool_start_ff <= csr_wdata;
            CSR_PAGE_COUNT: page_count_ff <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // pool size: smallest of page_count, MAX_PAGES and the room below 2^32
   assign base_pg = pool_start_ff[31:PAGE_SHIFT];
   always_comb begin
      room      = {1'b1, {PG_W{1'b0}}} - {1'b0, base_pg};
      pool_next = (PG_W + 1)'(page_count_ff);
      if (pool_next > (PG_W + 1)'(MAX_PAGES)) pool_next = (PG_W + 1)'(MAX_PAGES);
      if (pool_next > room) pool_next = room;
   end

   assign pool_pages = DEP_W'(pool_next);

   assign addr_pg   = req_address[31:PAGE_SHIFT];
   assign diff      = addr_pg - base_pg;
   assign in_range  = (addr_pg >= base_pg) &&
                      ({1'b0, diff} < (PG_W + 1)'(pool_pages));
   assign unaligned = (req_address[PAGE_SHIFT-1:0] != '0);
   assign req_idx   = diff[IDX_W-1:0];
   assign depth_dec = depth_ff - DEP_W'(1);

   assign cnt_re = (cmd.accept && in_range &&
                    (req_opcode == OP_RELEASE || req_opcode == OP_ADDREF ||
                     req_opcode == OP_READ)) || cmd.pop;
   assign cnt_raddr = cmd.pop ? stack_rd_ff : req_idx;
   assign stk_re    = cmd.accept && (req_opcode == OP_ALLOC) && (depth_ff != '0);

   assign sweep_last = (sweep_ff == IDX_W'(MAX_PAGES - 1));

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff        <= req_opcode;
         unaligned_ff <= unaligned;
         bad_ff       <= !in_range;
         idx_ff       <= req_idx;
      end else if (cmd.pop) begin
         idx_ff <= stack_rd_ff;
      end
   end

   always_comb begin
      st_c      = STAT_OK;
      paddr_c   = '0;
      cnt_c     = '0;
      freed_c   = 1'b0;
      cnt_we    = 1'b0;
      cnt_wdata = count_rd_ff;
      push      = 1'b0;
      depth_in  = depth_ff;
      case (op_ff)
         OP_ALLOC: begin
            if (depth_ff == '0) begin
               st_c = STAT_EMPTY;
            end else begin
               depth_in = depth_dec;
               paddr_c  = {base_pg + PG_W'(idx_ff), {PAGE_SHIFT{1'b0}}};
               if (count_rd_ff != '0) begin
                  // page was referenced while free: leave its count alone
                  st_c  = STAT_NONZERO;
                  cnt_c = count_rd_ff;
               end else begin
                  cnt_we    = 1'b1;
                  cnt_wdata = COUNT_BITS'(1);
                  cnt_c     = COUNT_BITS'(1);
               end
            end
         end
         OP_RELEASE: begin
            if (unaligned_ff || bad_ff) begin
               st_c = STAT_BADADDR;
            end else if (count_rd_ff == '0) begin
               st_c = STAT_UNDER;
            end else begin
               cnt_we    = 1'b1;
               cnt_wdata = count_rd_ff - COUNT_BITS'(1);
               cnt_c     = cnt_wdata;
               // a full stack drops the push
               if (cnt_wdata == '0 && depth_ff < DEP_W'(MAX_PAGES)) begin
                  push     = 1'b1;
                  depth_in = depth_ff + DEP_W'(1);
                  freed_c  = 1'b1;
               end
            end
         end
         OP_ADDREF: begin
            if (bad_ff) begin
               st_c = STAT_BADADDR;
            end else if (count_rd_ff == CNT_MAX) begin
               st_c  = STAT_OVER;
               cnt_c = count_rd_ff;
            end else begin
               cnt_we    = 1'b1;
               cnt_wdata = count_rd_ff + COUNT_BITS'(1);
               cnt_c     = cnt_wdata;
            end
         end
         OP_READ: begin
            if (bad_ff) st_c = STAT_BADADDR;
            else cnt_c = count_rd_ff;
         end
         OP_INIT: depth_in = pool_pages;
         default: ;
      endcase
   end

   // count memory: clearing sweep or read-modify-write
   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         count_mem[sweep_ff] <= '0;
      end else if (cmd.commit && cnt_we) begin
         count_mem[idx_ff] <= cnt_wdata;
      end
      if (cnt_re) count_rd_ff <= count_mem[cnt_raddr];
   end

   // free stack memory
   always_ff @(posedge clock) begin
      if (cmd.sweep_init) begin
         if (DEP_W'(sweep_ff) < pool_pages) stack_mem[sweep_ff] <= sweep_ff;
      end else if (cmd.commit && push) begin
         stack_mem[depth_ff[IDX_W-1:0]] <= idx_ff;
      end
      if (stk_re) stack_rd_ff <= stack_mem[depth_dec[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         sweep_ff <= '0;
      end else begin
         if (cmd.commit) depth_ff <= depth_in;
         if (cmd.sweep) sweep_ff <= sweep_last ? '0 : sweep_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff       <= st_c;
         rsp_page_address_ff <= paddr_c;
         rsp_ref_count_ff    <= 16'(cnt_c);
         rsp_page_freed_ff   <= freed_c;
      end
   end

   assign stat.empty      = (depth_ff == '0);
   assign stat.sweep_last = sweep_last;
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_page_address = rsp_page_address_ff;
   assign rsp_ref_count    = rsp_ref_count_ff;
   assign rsp_page_freed   = rsp_page_freed_ff;

endmodule

`default_nettype wire

// ----- rtl/core/page_allocator_with_refcounts_top.sv -----
// Page allocator with per-page reference counts.
// Request channel (req_*): opcode and byte address, one response per request.
// Response channel (rsp_*): status, allocated page address, reference count
// after the operation, and a flag when a release put the page back on the
// free stack. Both channels move a request when valid is high and stall low.
// Registers pool_start (index 0) and page_count (index 1) are written through
// csr_write_en / csr_index / csr_wdata; the user must write them only while
// the block is idle, which the block itself does not enforce.
// rsp_valid rises when the modify state commits the request and the response
// register is free. Release, add reference, read count and rejected requests go
// straight to modify; allocate from a non-empty stack reads the free stack before
// the count; initialize first clears all MAX_PAGES counts, one per cycle, and
// rebuilds the free stack entries below the pool size. A new request is taken
// only once the previous one is committed. After reset all counts are cleared
// with req_stall high; the stack is empty until initialize or a freeing release.
// A stalled response is held in its register; the next request is still
// accepted and waits for the register before its result is loaded.
// Depends on pgalloc_pkg, pgalloc_ctrl and pgalloc_dpath.
`default_nettype none

module page_allocator_with_refcounts_top #(
   parameter int MAX_PAGES  = 4096,
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_page_address,
   output logic [15:0] rsp_ref_count,
   output logic        rsp_page_freed
);
   import pgalloc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   pgalloc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   pgalloc_dpath #(
      .MAX_PAGES  (MAX_PAGES),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_opcode       (req_opcode),
      .req_address      (req_address),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_page_address (rsp_page_address),
      .rsp_ref_count    (rsp_ref_count),
      .rsp_page_freed   (rsp_page_freed)
   );

endmodule

`default_nettype wire

// ----- rtl/core/pgalloc_checker.sv -----
// pgalloc_checker: port-level assertions for the page allocator, and the
// bind that attaches them to page_allocator_with_refcounts_top.
// Depends on pgalloc_pkg for the status codes.
`default_nettype none

module pgalloc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_page_address,
   input logic [15:0] rsp_ref_count,
   input logic        rsp_page_freed
);
   import pgalloc_pkg::*;

   // one request in flight: an accepted request closes the input side
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous one still in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) &&
         $stable(rsp_page_address) && $stable(rsp_ref_count) &&
         $stable(rsp_page_freed)))
      else $error("stalled response changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= STAT_NONZERO))
      else $error("response status out of range");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_EMPTY) |->
         (rsp_page_address == '0 && rsp_ref_count == '0 && !rsp_page_freed))
      else $error("empty pool response carries data");

   // a page goes back on the stack only when its count reached zero
   a_freed_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_page_freed) |->
         (rsp_status == STAT_OK && rsp_ref_count == '0))
      else $error("page freed with nonzero count or error status");

endmodule

bind page_allocator_with_refcounts_top pgalloc_checker u_checker (.*);

`default_nettype wire
